[hw/rtl/rvlm_pkg.sv]
package rvlm_pkg;

    localparam int MAX_BLOCK_SAMPLES_DEF = 512;

    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = SAMPLE_W + 1;
    // square of a magnitude up to 32768 fits in 31 bits
    localparam int SQ_W     = 2 * SAMPLE_W - 1;
    localparam int LEVEL_W  = 7;
    localparam int M_TDATA_W = 8;

    localparam int FULL_SCALE_SQ_W = 30;
    localparam logic [FULL_SCALE_SQ_W-1:0] FULL_SCALE_SQ = 30'd1073676289; // 32767^2
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;
    localparam int LEVEL_SCALE_SQ = 10000;  // 100^2
    localparam int LEVEL_SCALE_SQ_W = 14;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
    } qstat_t;

endpackage

[hw/rtl/rvlm_front.sv]
module rvlm_front #(
    parameter int MAX_BLOCK_SAMPLES = rvlm_pkg::MAX_BLOCK_SAMPLES_DEF,
    parameter int CNT_W = $clog2(MAX_BLOCK_SAMPLES + 1),
    parameter int SUM_W = rvlm_pkg::SQ_W + $clog2(MAX_BLOCK_SAMPLES + 1),
    parameter int ENTRY_W = 1 + CNT_W + SUM_W
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          meter_enable,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rvlm_pkg::SAMPLE_W-1:0] s_tdata,
    input  logic                          s_tlast,
    input  rvlm_pkg::qstat_t              q_stat,
    output logic                          push,
    output logic [ENTRY_W-1:0]            push_data
);

    logic                        st_valid_reg;
    logic                        st_last_reg;
    logic                        st_keep_reg;
    logic [rvlm_pkg::SQ_W-1:0]   st_sq_reg;
    logic [CNT_W-1:0]            st_cnt_reg;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [SUM_W-1:0]            sum_reg, sum_next;

    logic                        accept;
    logic                        keep;
    logic [CNT_W-1:0]            cnt_after;
    logic [rvlm_pkg::MAG_W-1:0]  mag;
    logic [2*rvlm_pkg::MAG_W-1:0] sq_full;
    logic [SUM_W-1:0]            sum_add;
    logic [rvlm_pkg::QCNT_W:0]   slots_used;

    // a last word still in the stage will take a queue slot next cycle
    assign slots_used = {1'b0, q_stat.count} +
                        (rvlm_pkg::QCNT_W + 1)'(st_valid_reg & st_last_reg);
    assign s_tready   = slots_used < (rvlm_pkg::QCNT_W + 1)'(rvlm_pkg::QUEUE_DEPTH);
    assign accept     = s_tvalid & s_tready;

    assign mag = s_tdata[rvlm_pkg::SAMPLE_W-1]
               ? (rvlm_pkg::MAG_W'(1 << rvlm_pkg::SAMPLE_W) - {1'b0, s_tdata})
               : {1'b0, s_tdata};
    assign sq_full = mag * mag;

    // samples past the block limit are dropped
    assign keep      = cnt_reg < CNT_W'(MAX_BLOCK_SAMPLES);
    assign cnt_after = keep ? cnt_reg + CNT_W'(1) : cnt_reg;

    always_comb begin
        cnt_next = cnt_reg;
        if (accept) begin
            cnt_next = s_tlast ? '0 : cnt_after;
        end
    end

    assign sum_add = sum_reg + (st_keep_reg ? SUM_W'(st_sq_reg) : '0);

    always_comb begin
        sum_next = sum_reg;
        if (st_valid_reg) begin
            sum_next = st_last_reg ? '0 : sum_add;
        end
    end

    assign push      = st_valid_reg & st_last_reg;
    assign push_data = {meter_enable, st_cnt_reg, sum_add};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
            cnt_reg      <= '0;
            sum_reg      <= '0;
        end else begin
            st_valid_reg <= accept;
            cnt_reg      <= cnt_next;
            sum_reg      <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_last_reg <= s_tlast;
            st_keep_reg <= keep;
            st_sq_reg   <= sq_full[rvlm_pkg::SQ_W-1:0];
            st_cnt_reg  <= cnt_after;
        end
    end

endmodule

[hw/rtl/rvlm_queue.sv]
module rvlm_queue #(
    parameter int ENTRY_W = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  logic [ENTRY_W-1:0]   push_data,
    input  logic                 pop,
    output logic [ENTRY_W-1:0]   pop_data,
    output rvlm_pkg::qstat_t     q_stat
);

    logic [ENTRY_W-1:0]              entry_reg [rvlm_pkg::QUEUE_DEPTH];
    logic [rvlm_pkg::QPTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [rvlm_pkg::QCNT_W-1:0]     cnt_reg, cnt_next;

    assign pop_data     = entry_reg[rd_ptr_reg];
    assign q_stat.count = cnt_reg;
    assign q_stat.empty = (cnt_reg == '0);

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + rvlm_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - rvlm_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + rvlm_pkg::QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + rvlm_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hw/rtl/rvlm_back.sv]
module rvlm_back #(
    parameter int MAX_BLOCK_SAMPLES = rvlm_pkg::MAX_BLOCK_SAMPLES_DEF,
    parameter int CNT_W = $clog2(MAX_BLOCK_SAMPLES + 1),
    parameter int SUM_W = rvlm_pkg::SQ_W + $clog2(MAX_BLOCK_SAMPLES + 1),
    parameter int ENTRY_W = 1 + CNT_W + SUM_W
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  rvlm_pkg::qstat_t               q_stat,
    input  logic [ENTRY_W-1:0]             pop_data,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rvlm_pkg::M_TDATA_W-1:0] m_tdata
);

    // count * L^2 for L up to 100
    localparam int Q_W   = $clog2(MAX_BLOCK_SAMPLES * rvlm_pkg::LEVEL_SCALE_SQ + 1);
    localparam int P_W   = Q_W + rvlm_pkg::FULL_SCALE_SQ_W;
    localparam int RHS_W = SUM_W + rvlm_pkg::LEVEL_SCALE_SQ_W;
    localparam int CMP_W = (P_W > RHS_W) ? P_W : RHS_W;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RHS  = 5'b00010,
        ST_MULT = 5'b00100,
        ST_CMP  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t                          state_reg, state_next;
    logic                            en_reg;
    logic [CNT_W-1:0]                cnt_reg;
    logic [SUM_W-1:0]                sum_reg;
    logic [RHS_W-1:0]                rhs_reg;
    logic [Q_W-1:0]                  q_reg, q_next;
    logic [Q_W-1:0]                  inc_reg, inc_next;
    logic [P_W-1:0]                  prod_reg;
    logic [rvlm_pkg::LEVEL_W-1:0]    lvl_reg, lvl_next;
    logic [rvlm_pkg::LEVEL_W-1:0]    best_reg, best_next;
    logic                            out_valid_reg, out_valid_next;
    logic [rvlm_pkg::LEVEL_W-1:0]    out_level_reg;

    logic [RHS_W-1:0]                sum_x;
    logic [RHS_W-1:0]                rhs_calc;
    logic [Q_W-1:0]                  cnt_q;
    logic                            fits;
    logic                            out_free;

    assign sum_x = RHS_W'(sum_reg);
    // sum * 10000 as shifted adds: 8192 + 1024 + 512 + 256 + 16
    assign rhs_calc = (sum_x << 13) + (sum_x << 10) + (sum_x << 9) + (sum_x << 8) + (sum_x << 4);
    assign cnt_q    = Q_W'(cnt_reg);
    assign fits     = CMP_W'(prod_reg) <= CMP_W'(rhs_reg);
    assign out_free = !out_valid_reg || m_tready;
    assign pop      = (state_reg == ST_IDLE) && !q_stat.empty;

    always_comb begin
        state_next     = state_reg;
        q_next         = q_reg;
        inc_next       = inc_reg;
        lvl_next       = lvl_reg;
        best_next      = best_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (!q_stat.empty) begin
                    state_next = ST_RHS;
                end
            end
            ST_RHS: begin
                // walk L upward from 1, keeping count*L^2 and count*(2L+1)
                lvl_next  = rvlm_pkg::LEVEL_W'(1);
                best_next = '0;
                q_next    = cnt_q;
                inc_next  = cnt_q + (cnt_q << 1);
                if (!en_reg || cnt_reg == '0) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_MULT;
                end
            end
            ST_MULT: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (fits) begin
                    best_next = lvl_reg;
                    if (lvl_reg == rvlm_pkg::LEVEL_MAX) begin
                        state_next = ST_OUT;
                    end else begin
                        lvl_next   = lvl_reg + rvlm_pkg::LEVEL_W'(1);
                        q_next     = q_reg + inc_reg;
                        inc_next   = inc_reg + (cnt_q << 1);
                        state_next = ST_MULT;
                    end
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg    <= q_next;
        inc_reg  <= inc_next;
        lvl_reg  <= lvl_next;
        best_reg <= best_next;
        if (pop) begin
            en_reg  <= pop_data[ENTRY_W-1];
            cnt_reg <= pop_data[SUM_W +: CNT_W];
            sum_reg <= pop_data[SUM_W-1:0];
        end
        if (state_reg == ST_RHS) begin
            rhs_reg <= rhs_calc;
        end
        if (state_reg == ST_MULT) begin
            prod_reg <= q_reg * rvlm_pkg::FULL_SCALE_SQ;
        end
        if (state_reg == ST_OUT && out_free) begin
            out_level_reg <= best_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = rvlm_pkg::M_TDATA_W'(out_level_reg);

endmodule

[hw/rtl/rms_volume_level_meter.sv]
// rms volume level meter
//
// s_ channel: one signed 16-bit audio sample per word, s_tlast on the final
// sample of a block. samples are taken one per cycle while s_tready is high;
// the squares are summed with a sample count (samples past MAX_BLOCK_SAMPLES
// in a block are dropped, the last one still closes the block).
// m_ channel: one word per block, the level 0..100 in m_tdata[6:0].
// cfg_ channel: cfg_data is meter_enable; when it is low every block reports 0.
// write it only while no block is in flight. cfg_ready is always high.
//
// search path: the closed block passes the square stage register into a
// two-entry queue; the level search then runs its setup (pop, sum * 10000),
// then per level step one multiply by 32767^2 and one compare, then an output
// step. the back end works on one block at a time and takes the next block
// from the queue only after its result is handed to the output register, so
// short blocks stall s_tready once two results are pending.
// when m_tready is low the result holds in the output register while the
// next block's search runs; the queue then fills and s_tready drops.
// reset (aresetn low, synchronous) clears the sums, the queue and the
// output, and sets meter_enable to 0.
module rms_volume_level_meter #(
    parameter int MAX_BLOCK_SAMPLES = rvlm_pkg::MAX_BLOCK_SAMPLES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rvlm_pkg::SAMPLE_W-1:0]  s_tdata,   // [15:0] sample
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rvlm_pkg::M_TDATA_W-1:0] m_tdata,   // [6:0] level, [7] zero
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_data
);

    localparam int CNT_W   = $clog2(MAX_BLOCK_SAMPLES + 1);
    localparam int SUM_W   = rvlm_pkg::SQ_W + $clog2(MAX_BLOCK_SAMPLES + 1);
    localparam int ENTRY_W = 1 + CNT_W + SUM_W;

    logic                 enable_reg;
    logic                 push;
    logic                 pop;
    logic [ENTRY_W-1:0]   push_data;
    logic [ENTRY_W-1:0]   pop_data;
    rvlm_pkg::qstat_t     q_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
        end else if (cfg_valid) begin
            enable_reg <= cfg_data;
        end
    end

    rvlm_front #(
        .MAX_BLOCK_SAMPLES (MAX_BLOCK_SAMPLES),
        .CNT_W             (CNT_W),
        .SUM_W             (SUM_W),
        .ENTRY_W           (ENTRY_W)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .meter_enable (enable_reg),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .q_stat       (q_stat),
        .push         (push),
        .push_data    (push_data)
    );

    rvlm_queue #(
        .ENTRY_W (ENTRY_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    rvlm_back #(
        .MAX_BLOCK_SAMPLES (MAX_BLOCK_SAMPLES),
        .CNT_W             (CNT_W),
        .SUM_W             (SUM_W),
        .ENTRY_W           (ENTRY_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .pop_data (pop_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
